@@ hdl/mve_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, command codes and fixed-point helpers for the matrix-vector engine.
// No dependencies.
package mve_pkg;

  // Input commands
  typedef enum logic [3:0] {
    CMD_WRITE     = 4'd0,
    CMD_READ      = 4'd1,
    CMD_ADD_SCAL  = 4'd2,
    CMD_SUB_SCAL  = 4'd3,
    CMD_MUL_SCAL  = 4'd4,
    CMD_ELEM_ADD  = 4'd5,
    CMD_ELEM_SUB  = 4'd6,
    CMD_ELEM_MUL  = 4'd7,
    CMD_LOAD_VEC  = 4'd8,
    CMD_MULTIPLY  = 4'd9
  } cmd_t;

  // Configuration register indexes
  localparam logic [3:0] CFG_ROWS_IDX = 4'd0;
  localparam logic [3:0] CFG_COLS_IDX = 4'd1;
  localparam int         CFG_IDX_W    = 4;
  localparam int         CFG_DATA_W   = 5;

  // Field widths
  localparam int CMD_W   = 4;
  localparam int IDX_W   = 4;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 8;

  // Operation carried by a token through the cell chain
  typedef enum logic [2:0] {
    TK_WRITE,
    TK_ADD,
    TK_SUB,
    TK_MUL,
    TK_READ,
    TK_MAC,
    TK_LOADV
  } tok_kind_t;

  // Token handed from cell to cell
  typedef struct packed {
    logic                     valid;
    tok_kind_t                kind;
    logic                     every;   // applies to all in-use columns
    logic                     hit;     // single target lies in the in-use region
    logic                     emit;    // produces a result at the chain end
    logic                     last;
    logic [ADDR_W-1:0]        row;
    logic [ADDR_W-1:0]        col;
    logic [IDX_W-1:0]         res_row;
    logic signed [DATA_W-1:0] val;
  } tok_t;

  // Clamp a 64-bit value to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (x < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

@@ hdl/mve_in_if.sv @@
`timescale 1ns / 1ps
// Input item channel of the matrix-vector engine.
// Depends on mve_pkg.
interface mve_in_if import mve_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic [IDX_W-1:0]         row;
  logic [IDX_W-1:0]         col;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, command, row, col, value, input ready);
  modport sink   (input valid, command, row, col, value, output ready);
endinterface

@@ hdl/mve_out_if.sv @@
`timescale 1ns / 1ps
// Result item channel of the matrix-vector engine.
// Depends on mve_pkg.
interface mve_out_if import mve_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] result;
  logic [IDX_W-1:0]         result_row;
  logic                     last;

  modport source (output valid, result, result_row, last, input ready);
  modport sink   (input valid, result, result_row, last, output ready);
endinterface

@@ hdl/mve_cfg_if.sv @@
`timescale 1ns / 1ps
// Configuration write channel of the matrix-vector engine.
// Depends on mve_pkg.
interface mve_cfg_if import mve_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/mve_cell.sv @@
`timescale 1ns / 1ps
// One column cell: holds a matrix column, its vector element and a MAC/ALU stage.
// Depends on mve_pkg.
module mve_cell import mve_pkg::*; #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16,
  parameter int CELL_IDX = 0,
  parameter int SUM_W    = 53
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [$clog2(MAX_COLS+1)-1:0]    nc,
  input  tok_t                             tok_in,
  output tok_t                             tok_out,
  input  logic signed [SUM_W-1:0]          psum_in,
  output logic signed [SUM_W-1:0]          psum_out
);

  localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic [DATA_W-1:0]        mem_r [MAX_ROWS];
  logic [MAX_ROWS-1:0]      vld_r;
  logic signed [DATA_W-1:0] vec_r;
  tok_t                     a_tok_r, b_tok_r;
  logic                     a_en_r, b_en_r;
  logic [DATA_W-1:0]        rd_r;
  logic                     rd_vld_r;
  logic signed [63:0]       b_val_r;
  logic signed [63:0]       b_val_nxt;
  logic signed [SUM_W-1:0]  psum_r, psum_nxt;

  logic                     en;
  logic signed [DATA_W-1:0] elem, opnd;
  logic signed [63:0]       rnd, v64;
  logic                     is_mul, is_upd, is_sum;
  logic [RIW-1:0]           a_idx, c_idx;

  // Decide whether this column takes part
  always_comb begin
    if (tok_in.every) begin
      en = tok_in.valid && (32'(CELL_IDX) < 32'(nc));
    end else begin
      en = tok_in.valid && tok_in.hit && (tok_in.col == ADDR_W'(CELL_IDX));
    end
  end

  assign a_idx = tok_in.row[RIW-1:0];
  assign c_idx = b_tok_r.row[RIW-1:0];

  // Stage A: read the column entry, advance the token
  always_ff @(posedge clk) begin
    rd_r <= mem_r[a_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_tok_r  <= '0;
      a_en_r   <= 1'b0;
      rd_vld_r <= 1'b0;
      vec_r    <= '0;
    end else begin
      a_tok_r  <= tok_in;
      a_en_r   <= en;
      rd_vld_r <= vld_r[a_idx];
      if (en && tok_in.kind == TK_LOADV) begin
        vec_r <= tok_in.val;
      end
    end
  end

  // Stage B: add, subtract or multiply
  assign elem = rd_vld_r ? $signed(rd_r) : '0;
  assign opnd = (a_tok_r.kind == TK_MAC) ? vec_r : a_tok_r.val;

  always_comb begin
    case (a_tok_r.kind)
      TK_WRITE: b_val_nxt = 64'(a_tok_r.val);
      TK_ADD:   b_val_nxt = 64'(elem) + 64'(a_tok_r.val);
      TK_SUB:   b_val_nxt = 64'(elem) - 64'(a_tok_r.val);
      TK_MUL:   b_val_nxt = 64'(elem) * 64'(opnd);
      TK_MAC:   b_val_nxt = 64'(elem) * 64'(opnd);
      TK_READ:  b_val_nxt = 64'(elem);
      default:  b_val_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    b_val_r <= b_val_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_tok_r <= '0;
      b_en_r  <= 1'b0;
    end else begin
      b_tok_r <= a_tok_r;
      b_en_r  <= a_en_r;
    end
  end

  // Stage C: round products, write back, accumulate the row sum
  assign is_mul = (b_tok_r.kind == TK_MUL) || (b_tok_r.kind == TK_MAC);
  assign is_upd = (b_tok_r.kind == TK_WRITE) || (b_tok_r.kind == TK_ADD) ||
                  (b_tok_r.kind == TK_SUB) || (b_tok_r.kind == TK_MUL);
  assign is_sum = (b_tok_r.kind == TK_MAC) || (b_tok_r.kind == TK_READ);
  assign rnd    = (b_val_r + 64'sd32768) >>> 16;
  assign v64    = is_mul ? rnd : b_val_r;

  always_comb begin
    if (b_tok_r.valid && b_en_r && is_sum) begin
      psum_nxt = psum_in + SUM_W'(v64);
    end else begin
      psum_nxt = psum_in;
    end
  end

  always_ff @(posedge clk) begin
    if (b_tok_r.valid && b_en_r && is_upd) begin
      mem_r[c_idx] <= sat32(v64);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (b_tok_r.valid && b_en_r && is_upd) begin
      vld_r[c_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    psum_r <= psum_nxt;
  end

  assign tok_out  = a_tok_r;
  assign psum_out = psum_r;

endmodule

@@ hdl/matrix_vector_engine.sv @@
`timescale 1ns / 1ps
// Matrix-vector engine: a chain of MAX_COLS column cells, one token per row.
// Items are accepted only while the sequencer is idle. A product issues its rows one at
// a time, each row draining through the chain before the next, and a result item waits
// on the receiver before it is issued. Synchronous active-low reset clears the matrix
// valid bits and the vector and sets both config counts to 16.
module matrix_vector_engine import mve_pkg::*; #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  mve_in_if.sink      in_if,
  mve_out_if.source   out_if,
  mve_cfg_if.sink     cfg_if
);

  localparam int NRW   = $clog2(MAX_ROWS + 1);
  localparam int NCW   = $clog2(MAX_COLS + 1);
  localparam int SUM_W = 49 + $clog2(MAX_COLS);
  localparam int LAT   = MAX_COLS + 4;
  localparam int WTW   = $clog2(LAT + 1);

  typedef enum logic [1:0] {SEQ_IDLE, SEQ_ISSUE, SEQ_DRAIN} seq_state_t;

  seq_state_t               state_r, state_nxt;
  logic [CFG_DATA_W-1:0]    rows_r, cols_r;
  logic [CMD_W-1:0]         cmd_r;
  logic [IDX_W-1:0]         row_r, col_r;
  logic signed [DATA_W-1:0] val_r;
  logic [NRW-1:0]           rcnt_r, rcnt_nxt;
  logic [WTW-1:0]           wait_r, wait_nxt;
  logic [NRW-1:0]           nr;
  logic [NCW-1:0]           nc;
  logic                     in_region, more_rows, is_scal, is_prod, issue_go;
  tok_t                     issue_tok;
  tok_t                     tok_w [MAX_COLS];
  logic signed [SUM_W-1:0]  psum_w [MAX_COLS];
  tok_t                     tail1_r, tail2_r;
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_result_r;
  logic [IDX_W-1:0]         out_row_r;
  logic                     out_last_r;
  logic                     accept;

  // Configuration registers
  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= CFG_DATA_W'(16);
      cols_r <= CFG_DATA_W'(16);
    end else if (cfg_if.valid) begin
      if (cfg_if.index == CFG_ROWS_IDX) begin
        rows_r <= cfg_if.data;
      end else if (cfg_if.index == CFG_COLS_IDX) begin
        cols_r <= cfg_if.data;
      end
    end
  end

  // Effective counts: zero reads as one, clamp at the maximum
  always_comb begin
    if (rows_r == '0) begin
      nr = NRW'(1);
    end else if (32'(rows_r) > 32'(MAX_ROWS)) begin
      nr = NRW'(MAX_ROWS);
    end else begin
      nr = NRW'(rows_r);
    end
    if (cols_r == '0) begin
      nc = NCW'(1);
    end else if (32'(cols_r) > 32'(MAX_COLS)) begin
      nc = NCW'(MAX_COLS);
    end else begin
      nc = NCW'(cols_r);
    end
  end

  assign in_region = (32'(row_r) < 32'(nr)) && (32'(col_r) < 32'(nc));
  assign more_rows = (32'(rcnt_r) + 32'd1) < 32'(nr);
  assign is_scal   = (cmd_r == CMD_ADD_SCAL) || (cmd_r == CMD_SUB_SCAL) ||
                     (cmd_r == CMD_MUL_SCAL);
  assign is_prod   = (cmd_r == CMD_MULTIPLY);
  assign accept    = in_if.valid && in_if.ready;

  // Sequencer outputs: build the token for the current row
  always_comb begin
    issue_tok         = '0;
    issue_tok.row     = ADDR_W'(row_r);
    issue_tok.col     = ADDR_W'(col_r);
    issue_tok.val     = val_r;
    issue_tok.hit     = in_region;
    issue_tok.res_row = row_r;
    issue_tok.last    = 1'b1;
    case (cmd_r)
      CMD_WRITE:    issue_tok.kind = TK_WRITE;
      CMD_READ: begin
        issue_tok.kind = TK_READ;
        issue_tok.emit = 1'b1;
      end
      CMD_ADD_SCAL: issue_tok.kind = TK_ADD;
      CMD_SUB_SCAL: issue_tok.kind = TK_SUB;
      CMD_MUL_SCAL: issue_tok.kind = TK_MUL;
      CMD_ELEM_ADD: issue_tok.kind = TK_ADD;
      CMD_ELEM_SUB: issue_tok.kind = TK_SUB;
      CMD_ELEM_MUL: issue_tok.kind = TK_MUL;
      CMD_LOAD_VEC: begin
        issue_tok.kind = TK_LOADV;
        issue_tok.hit  = 32'(col_r) < 32'(nc);
      end
      CMD_MULTIPLY: begin
        issue_tok.kind    = TK_MAC;
        issue_tok.emit    = 1'b1;
        issue_tok.res_row = rcnt_r[IDX_W-1:0] & {IDX_W{1'b1}};
        issue_tok.last    = !more_rows;
      end
      default:      issue_tok.kind = TK_WRITE;
    endcase
    if (is_scal || is_prod) begin
      issue_tok.every = 1'b1;
      issue_tok.row   = ADDR_W'(rcnt_r);
    end
    if (is_prod) begin
      issue_tok.res_row = IDX_W'(rcnt_r);
    end
    issue_go        = (state_r == SEQ_ISSUE) && (!issue_tok.emit || !out_valid_r);
    issue_tok.valid = issue_go;
  end

  assign in_if.ready = (state_r == SEQ_IDLE);

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    rcnt_nxt  = rcnt_r;
    wait_nxt  = wait_r;
    case (state_r)
      SEQ_IDLE: begin
        rcnt_nxt = '0;
        if (accept && (in_if.command <= CMD_MULTIPLY)) begin
          state_nxt = SEQ_ISSUE;
        end
      end
      SEQ_ISSUE: begin
        if (issue_go) begin
          if (is_scal && more_rows) begin
            rcnt_nxt = rcnt_r + NRW'(1);
          end else begin
            state_nxt = SEQ_DRAIN;
            wait_nxt  = WTW'(LAT);
          end
        end
      end
      SEQ_DRAIN: begin
        if (wait_r != '0) begin
          wait_nxt = wait_r - WTW'(1);
        end else if (is_prod && more_rows) begin
          rcnt_nxt  = rcnt_r + NRW'(1);
          state_nxt = SEQ_ISSUE;
        end else begin
          state_nxt = SEQ_IDLE;
        end
      end
      default: state_nxt = SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_IDLE;
      rcnt_r  <= '0;
      wait_r  <= '0;
    end else begin
      state_r <= state_nxt;
      rcnt_r  <= rcnt_nxt;
      wait_r  <= wait_nxt;
    end
  end

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_if.command;
      row_r <= in_if.row;
      col_r <= in_if.col;
      val_r <= in_if.value;
    end
  end

  // Column cell chain
  for (genvar i = 0; i < MAX_COLS; i++) begin : g_cell
    tok_t                    tin;
    logic signed [SUM_W-1:0] pin;
    if (i == 0) begin : g_head
      assign tin = issue_tok;
      assign pin = '0;
    end else begin : g_link
      assign tin = tok_w[i-1];
      assign pin = psum_w[i-1];
    end
    mve_cell #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS),
      .CELL_IDX (i),
      .SUM_W    (SUM_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .nc       (nc),
      .tok_in   (tin),
      .tok_out  (tok_w[i]),
      .psum_in  (pin),
      .psum_out (psum_w[i])
    );
  end

  // Align the token with the final row sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tail1_r <= '0;
      tail2_r <= '0;
    end else begin
      tail1_r <= tok_w[MAX_COLS-1];
      tail2_r <= tail1_r;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (tail2_r.valid && tail2_r.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tail2_r.valid && tail2_r.emit) begin
      out_result_r <= sat32(64'(psum_w[MAX_COLS-1]));
      out_row_r    <= tail2_r.res_row;
      out_last_r   <= tail2_r.last;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.result     = out_result_r;
  assign out_if.result_row = out_row_r;
  assign out_if.last       = out_last_r;

endmodule
